>>> src/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> src/kdq_pkg.sv
package kdq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    // request codes
    typedef logic [2:0] req_code_t;
    localparam req_code_t REQ_PUSH_BACK  = 3'd0;
    localparam req_code_t REQ_POP_BACK   = 3'd1;
    localparam req_code_t REQ_PEEK_BACK  = 3'd2;
    localparam req_code_t REQ_POP_FRONT  = 3'd3;
    localparam req_code_t REQ_PUSH_FRONT = 3'd4;
    localparam req_code_t REQ_FIND       = 3'd5;

    // which ring slot the store read port looks at
    typedef enum logic [1:0] {
        RD_BACK  = 2'd0,
        RD_FRONT = 2'd1,
        RD_SCAN  = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    cap_in;
        logic    wr_en;
        logic    wr_at_front;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    scan_init;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    front_next;
        logic    front_prev;
        logic    res_load;
        logic    res_ok;
        logic    res_use_rd;
    } kdq_cmd_t;

    typedef struct packed {
        req_code_t req;
        logic      full;
        logic      empty;
        logic      key_hit;
        logic      scan_last;
    } kdq_status_t;

endpackage

>>> src/keyed_double_ended_queue_unit.sv
// steps from input beat to result: push captures the request, then writes the store
// and loads the result; pop, peek and find read the store first, find entry by entry
// one request at a time; next input beat is taken the cycle after the result loads
// find speed is set by the single read port of the key store, one entry per cycle
// reset (rst_n, async, active low) empties the queue: count and front slot clear,
// stores keep their contents and are only read where an entry was written
`include "assert_macros.svh"

module keyed_double_ended_queue_unit #(
    parameter int CAPACITY  = kdq_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = kdq_pkg::WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     req_type,
    input  logic [WORD_BITS-1:0]           entry_key,
    input  logic [WORD_BITS-1:0]           entry_data,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output logic [WORD_BITS-1:0]           data_out,
    output logic [$clog2(CAPACITY+1)-1:0]  count
);
    import kdq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    kdq_cmd_t    cmd;
    kdq_status_t status;

    // controller: sequences one request, owns the result beat handshake
    kdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: ring pointers, key/data stores, scan counters, result register
    kdq_dpath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req_type),
        .entry_key  (entry_key),
        .entry_data (entry_data),
        .ok         (ok),
        .data_out   (data_out),
        .count      (count)
    );

    // entry count in a result never exceeds the ring size
    `ASSERT_SAME(a_count_bound, clk, rst_n, out_valid, count <= CNT_W'(CAPACITY))

    // a failed request always reports a zero data word
    `ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && !ok, data_out == '0)

    // one request in flight: an accepted beat blocks the next cycle
    `ASSERT_NEXT(a_one_busy, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

>>> src/kdq_dpath.sv
module kdq_dpath #(
    parameter int CAPACITY  = kdq_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = kdq_pkg::WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kdq_pkg::kdq_cmd_t              cmd,
    output kdq_pkg::kdq_status_t           status,
    input  logic [2:0]                     req_type,
    input  logic [WORD_BITS-1:0]           entry_key,
    input  logic [WORD_BITS-1:0]           entry_data,
    output logic                           ok,
    output logic [WORD_BITS-1:0]           data_out,
    output logic [$clog2(CAPACITY+1)-1:0]  count
);
    import kdq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);

    logic [WORD_BITS-1:0] key_mem  [CAPACITY];
    logic [WORD_BITS-1:0] data_mem [CAPACITY];

    logic [PTR_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PTR_W-1:0]     scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0]     scan_left_reg, scan_left_next;
    req_code_t            req_reg;
    logic [WORD_BITS-1:0] key_reg, data_reg;
    logic [WORD_BITS-1:0] rd_key_reg, rd_data_reg;
    logic                 ok_reg;
    logic [WORD_BITS-1:0] dout_reg;
    logic [CNT_W-1:0]     cnt_out_reg;

    logic [SUM_W-1:0] tail_sum, back_sum;
    logic [PTR_W-1:0] tail_slot, back_slot, front_inc, front_dec, scan_inc;
    logic [PTR_W-1:0] wr_addr, rd_addr;

    // ring slot arithmetic, one conditional subtract each
    always_comb
    begin
        tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
        back_sum  = tail_sum - SUM_W'(1);
        tail_slot = (tail_sum >= CAP_SUM) ? PTR_W'(tail_sum - CAP_SUM) : PTR_W'(tail_sum);
        back_slot = (back_sum >= CAP_SUM) ? PTR_W'(back_sum - CAP_SUM) : PTR_W'(back_sum);
        front_inc = (front_reg == LAST_PTR) ? '0 : front_reg + PTR_W'(1);
        front_dec = (front_reg == '0) ? LAST_PTR : front_reg - PTR_W'(1);
        scan_inc  = (scan_slot_reg == LAST_PTR) ? '0 : scan_slot_reg + PTR_W'(1);
        wr_addr   = cmd.wr_at_front ? front_dec : tail_slot;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_BACK:  rd_addr = back_slot;
            RD_FRONT: rd_addr = front_reg;
            RD_SCAN:  rd_addr = scan_slot_reg;
            default:  rd_addr = front_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.cnt_dec)
            count_next = count_reg - CNT_W'(1);

        front_next = front_reg;
        if (cmd.front_next)
            front_next = front_inc;
        else if (cmd.front_prev)
            front_next = front_dec;

        scan_slot_next = scan_slot_reg;
        scan_left_next = scan_left_reg;
        if (cmd.scan_init)
        begin
            scan_slot_next = front_inc;
            scan_left_next = count_reg - CNT_W'(1);
        end
        else if (cmd.rd_en && cmd.rd_sel == RD_SCAN)
        begin
            scan_slot_next = scan_inc;
            scan_left_next = scan_left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_slot_reg <= scan_slot_next;
        scan_left_reg <= scan_left_next;
        if (cmd.cap_in)
        begin
            req_reg  <= req_type;
            key_reg  <= entry_key;
            data_reg <= entry_data;
        end
        if (cmd.res_load)
        begin
            ok_reg      <= cmd.res_ok;
            dout_reg    <= cmd.res_use_rd ? rd_data_reg : '0;
            cnt_out_reg <= count_next;
        end
    end

    // key and data stores
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[wr_addr]  <= key_reg;
            data_mem[wr_addr] <= data_reg;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_data_reg <= data_mem[rd_addr];
        end
    end

    always_comb
    begin
        status.req       = req_reg;
        status.full      = (count_reg == CAP_CNT);
        status.empty     = (count_reg == '0);
        status.key_hit   = (rd_key_reg == key_reg);
        status.scan_last = (scan_left_reg == '0);
    end

    assign ok       = ok_reg;
    assign data_out = dout_reg;
    assign count    = cnt_out_reg;

endmodule

>>> src/kdq_ctrl.sv
module kdq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  kdq_pkg::kdq_status_t status,
    output kdq_pkg::kdq_cmd_t    cmd
);
    import kdq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_SCAN = 4'b1000
    } kdq_state_t;

    kdq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       go;

    // result register free this cycle
    assign go = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_FRONT;
        state_next = state_reg;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                case (status.req)
                    REQ_PUSH_BACK, REQ_PUSH_FRONT:
                    begin
                        if (go)
                        begin
                            if (!status.full)
                            begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_at_front = (status.req == REQ_PUSH_FRONT);
                                cmd.front_prev  = (status.req == REQ_PUSH_FRONT);
                                cmd.cnt_inc     = 1'b1;
                            end
                            cmd.res_load = 1'b1;
                            cmd.res_ok   = !status.full;
                            state_next   = ST_IDLE;
                        end
                    end

                    REQ_POP_BACK, REQ_PEEK_BACK, REQ_POP_FRONT:
                    begin
                        if (!status.empty)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = (status.req == REQ_POP_FRONT) ? RD_FRONT : RD_BACK;
                            state_next = ST_WAIT;
                        end
                        else if (go)
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end

                    REQ_FIND:
                    begin
                        if (!status.empty)
                        begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = RD_FRONT;
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        else if (go)
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end

                    default:
                    begin
                        if (go)
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_WAIT:
            begin
                if (go)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_ok     = 1'b1;
                    cmd.res_use_rd = 1'b1;
                    cmd.cnt_dec    = (status.req != REQ_PEEK_BACK);
                    cmd.front_next = (status.req == REQ_POP_FRONT);
                    state_next     = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (status.key_hit)
                begin
                    if (go)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_ok     = 1'b1;
                        cmd.res_use_rd = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (status.scan_last)
                begin
                    if (go)
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> sim/tb_top.sv
import kdq_pkg::*;

// one expected result beat of the deque
typedef struct packed {
    logic        ok;
    logic [31:0] data;
    logic [4:0]  count;
} dq_result_t;

// scoreboard: mirrors the ring of key/data pairs and queues the expected results
class dq_scoreboard;
    logic [31:0]  ring_keys [16];
    logic [31:0]  ring_words [16];
    logic [3:0]   head_slot;
    logic [4:0]   held;
    dq_result_t   pending [$];
    int           errors;

    function new();
        head_slot = '0;
        held      = '0;
        errors    = 0;
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // work out the result of one accepted request and update the mirror
    function void note_request(req_code_t req, logic [31:0] key, logic [31:0] word);
        dq_result_t r;
        logic [3:0] slot;
        r.ok   = 1'b0;
        r.data = '0;
        case (req)
            REQ_PUSH_BACK:
                if (held < 5'd16)
                begin
                    slot = head_slot + held[3:0];
                    ring_keys[slot]  = key;
                    ring_words[slot] = word;
                    held++;
                    r.ok = 1'b1;
                end
            REQ_POP_BACK, REQ_PEEK_BACK:
                if (held != 0)
                begin
                    slot = head_slot + held[3:0] - 4'd1;
                    r.data = ring_words[slot];
                    r.ok   = 1'b1;
                    if (req == REQ_POP_BACK)
                        held--;
                end
            REQ_POP_FRONT:
                if (held != 0)
                begin
                    r.data = ring_words[head_slot];
                    r.ok   = 1'b1;
                    head_slot++;
                    held--;
                end
            REQ_PUSH_FRONT:
                if (held < 5'd16)
                begin
                    head_slot--;
                    ring_keys[head_slot]  = key;
                    ring_words[head_slot] = word;
                    held++;
                    r.ok = 1'b1;
                end
            REQ_FIND:
                for (int i = 0; i < held; i++)
                begin
                    slot = head_slot + i[3:0];
                    if (ring_keys[slot] == key)
                    begin
                        r.data = ring_words[slot];
                        r.ok   = 1'b1;
                        break;
                    end
                end
            default: ;
        endcase
        r.count = held;
        pending.push_back(r);
    endfunction

    task check_result(logic ok, logic [31:0] data, logic [4:0] count);
        dq_result_t e;
        if (pending.size() == 0)
        begin
            report($sformatf("result with nothing expected: ok %0b data %h count %0d",
                             ok, data, count));
            return;
        end
        e = pending.pop_front();
        if (ok !== e.ok)
            report($sformatf("ok %b, expected %b", ok, e.ok));
        if (data !== e.data)
            report($sformatf("data_out %h, expected %h", data, e.data));
        if (count !== e.count)
            report($sformatf("count %0d, expected %0d", count, e.count));
    endtask
endclass

module tb_top;

    // request codes the block ignores
    localparam req_code_t REQ_UNUSED_A = 3'd6;
    localparam req_code_t REQ_UNUSED_B = 3'd7;

    // request mixes for the random part
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLD_AT_BEAT  = 200;   // result beat at which the receiver holds off
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either channel
    localparam int DRAIN_CYCLES  = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  req_type = '0;
    logic [31:0] entry_key = '0;
    logic [31:0] entry_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        ok;
    logic [31:0] data_out;
    logic [4:0]  count;

    dq_scoreboard sb = new();
    bit           no_idle = 1'b0;   // set for stretches where neither side waits
    int           result_beats = 0;
    int           quiet_cycles = 0;

    keyed_double_ended_queue_unit #(
        .CAPACITY  (16),
        .WORD_BITS (32)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .entry_key  (entry_key),
        .entry_data (entry_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .data_out   (data_out),
        .count      (count)
    );

    // 10 unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // mostly a small pool of keys so that finds hit, sometimes a full random word
    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 7)
            return 32'($urandom_range(0, 7));
        return $urandom;
    endfunction

    // weighted request code for the given mix
    function automatic req_code_t pick_req(int mix);
        int w [7];
        int r;
        case (mix)
            MIX_FILL:  w = '{35, 35, 6, 4, 6, 12, 2};
            MIX_DRAIN: w = '{8, 8, 30, 6, 30, 16, 2};
            default:   w = '{20, 20, 15, 8, 15, 20, 2};
        endcase
        r = $urandom_range(0, 99);
        if (r < w[0]) return REQ_PUSH_BACK;
        r -= w[0];
        if (r < w[1]) return REQ_PUSH_FRONT;
        r -= w[1];
        if (r < w[2]) return REQ_POP_BACK;
        r -= w[2];
        if (r < w[3]) return REQ_PEEK_BACK;
        r -= w[3];
        if (r < w[4]) return REQ_POP_FRONT;
        r -= w[4];
        if (r < w[5]) return REQ_FIND;
        return $urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B;
    endfunction

    // offer one request beat and hold it until the block takes it
    task automatic send_req(req_code_t req, logic [31:0] key, logic [31:0] word);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        entry_key  <= key;
        entry_data <= word;
        // in_ready sampled here is its value just before the edge
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_request(req, key, word);
    endtask

    // result side: random waits per beat, one long hold-off to back up the input
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = (result_beats == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(ok, data_out, count);
            result_beats++;
        end
    end

    // watchdog: ends the run when neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int mix;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: every take fails, finds miss, unused codes do nothing
        send_req(REQ_POP_BACK, 32'h0, 32'hFFFF_FFFF);
        send_req(REQ_PEEK_BACK, 32'h0, 32'h0);
        send_req(REQ_POP_FRONT, 32'hFFFF_FFFF, 32'h0);
        send_req(REQ_FIND, 32'h0, 32'h0);
        send_req(REQ_UNUSED_A, 32'h1234_5678, 32'h9ABC_DEF0);
        send_req(REQ_UNUSED_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // extreme keys and data at both ends
        send_req(REQ_PUSH_BACK, 32'h0, 32'hFFFF_FFFF);
        send_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 32'h0);
        send_req(REQ_FIND, 32'h0, 32'h0);
        send_req(REQ_FIND, 32'hFFFF_FFFF, 32'h0);
        send_req(REQ_PEEK_BACK, 32'h0, 32'h0);

        // fill to capacity, wrapping the ring at the front, then push into a full queue
        for (int i = 0; i < 14; i++)
            send_req(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, 32'(i + 1), $urandom);
        send_req(REQ_PUSH_BACK, 32'hAAAA_AAAA, 32'h5555_5555);
        send_req(REQ_PUSH_FRONT, 32'h5555_5555, 32'hAAAA_AAAA);
        // key at the back end of a full ring: the longest search
        send_req(REQ_FIND, 32'd13, 32'h0);
        send_req(REQ_POP_FRONT, 32'h0, 32'h0);
        send_req(REQ_POP_BACK, 32'h0, 32'h0);

        // random part: mix is drawn anew every 40 beats so the queue swings full and empty
        mix = MIX_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                mix = $urandom_range(MIX_FILL, MIX_EVEN);
            no_idle = (n >= 150 && n < 210);
            send_req(pick_req(mix), pick_key(), $urandom);
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        // let every expected beat arrive, then watch for strays
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
